FILE: src/fbpa_pkg.sv
package fbpa_pkg;

   // Default pool depth
   localparam int unsigned POOL_SLOTS_DEF = 256;

   // Field widths
   localparam int unsigned OFF_W    = 24;  // free offset
   localparam int unsigned AOFF_W   = 20;  // allocated offset
   localparam int unsigned COUNT_W  = 9;   // in-use and peak fields
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned SIZE_W   = 13;

   // Element size register
   localparam logic [SIZE_W-1:0] ESIZE_RESET = 13'd64;
   localparam logic [SIZE_W-1:0] ESIZE_MIN   = 13'd1;
   localparam logic [SIZE_W-1:0] ESIZE_MAX   = 13'd4096;

   // Opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NULL       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE_OUT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 3'd5;

   typedef struct packed {
      logic             opcode;
      logic             ptr_valid;
      logic [OFF_W-1:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [AOFF_W-1:0]   alloc_offset;
      logic [COUNT_W-1:0]  in_use;
      logic [COUNT_W-1:0]  peak_in_use;
   } rsp_type;

endpackage

FILE: src/fixed_block_pool_allocator_top.sv
// Fixed-size block pool allocator.
// Request channel (req_valid / req_stall / req_data): one word per request,
// opcode 0 allocates a block, opcode 1 frees the block at free_offset.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one word per
// request, in request order, with status, offset and the in-use counters.
// csr_wr_en / csr_wr_data write the element size; write it only while idle.
// Path from accept to response valid, with the response side open:
//   allocate         stack read, then the shift-add multiply of slot by
//                    element size, one bit a cycle, then write-back
//   free             the 24-step restoring divide of the offset by the
//                    element size, one quotient bit a cycle, then write-back
//   early rejection  to write-back (empty pool, null pointer, none outstanding)
// One request is in work at a time; req_stall is high until it is done.
// Both loops share one add/subtract unit.
// The response sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a finished request holds in write-back
// until the register frees, and state is committed only then.
// Reset: stack full with slot i at entry i, counters zero, element size 64.
// No clearing pass: a low-water mark of the stack pointer tells a stack entry
// never written since reset, which reads as its own index.
module fixed_block_pool_allocator_top #(
   parameter int unsigned POOL_SLOTS = fbpa_pkg::POOL_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  fbpa_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output fbpa_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [fbpa_pkg::SIZE_W-1:0]     csr_wr_data
);
   import fbpa_pkg::*;

   localparam int unsigned SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int unsigned TOP_W  = $clog2(POOL_SLOTS + 1);
   localparam int unsigned CNT_W  = $clog2(OFF_W + 1);
   localparam int unsigned UNIT_W = AOFF_W;

   // Sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;  // stack read data lands
   localparam logic [2:0] S_MUL  = 3'd2;  // slot * size, one bit a cycle
   localparam logic [2:0] S_DIV  = 3'd3;  // offset / size, one bit a cycle
   localparam logic [2:0] S_WB   = 3'd4;  // commit and load response

   // Free stack
   logic [SLOT_W-1:0] stack_mem [POOL_SLOTS];
   logic [SLOT_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   logic [SLOT_W-1:0] wr_data;

   logic [2:0]          state_ff, state_in;
   logic [SIZE_W-1:0]   esize_ff, esize_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic                op_ff, op_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [OFF_W-1:0]    q_ff, q_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [SLOT_W-1:0]   mul_ff, mul_in;
   logic [AOFF_W-1:0]   acc_ff, acc_in;
   logic [TOP_W-1:0]    top_ff, top_in;
   logic [TOP_W-1:0]    mark_ff, mark_in;
   logic [TOP_W-1:0]    used_ff, used_in;
   logic [TOP_W-1:0]    peak_ff, peak_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   // Shared add/subtract unit
   logic [UNIT_W-1:0] unit_a, unit_b;
   logic              unit_sub;
   logic [UNIT_W:0]   unit_sum;

   logic [SIZE_W:0]   div_shift;
   logic [SIZE_W-1:0] size_eff;
   logic [STATUS_W-1:0] final_status;

   assign unit_sum = {1'b0, unit_a} + {1'b0, (unit_sub ? ~unit_b : unit_b)}
                     + {{UNIT_W{1'b0}}, unit_sub};

   assign div_shift = {rem_ff, q_ff[OFF_W-1]};
   assign rd_addr   = SLOT_W'(top_ff - TOP_W'(1));

   always_comb begin
      if (esize_ff == '0) begin
         size_eff = ESIZE_MIN;
      end else if (esize_ff > ESIZE_MAX) begin
         size_eff = ESIZE_MAX;
      end else begin
         size_eff = esize_ff;
      end
   end

   always_comb begin
      unit_a   = {{(UNIT_W-SIZE_W-1){1'b0}}, div_shift};
      unit_b   = UNIT_W'(size_ff);
      unit_sub = 1'b1;
      if (state_ff == S_MUL) begin
         unit_a   = {acc_ff[AOFF_W-2:0], 1'b0};
         unit_b   = mul_ff[SLOT_W-1] ? UNIT_W'(size_ff) : '0;
         unit_sub = 1'b0;
      end
   end

   always_comb begin
      if (op_ff == OP_FREE && status_ff == ST_OK) begin
         if (q_ff >= OFF_W'(POOL_SLOTS)) begin
            final_status = ST_OUTSIDE;
         end else if (rem_ff != '0) begin
            final_status = ST_MISALIGNED;
         end else begin
            final_status = ST_OK;
         end
      end else begin
         final_status = status_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      esize_in     = csr_wr_en ? csr_wr_data : esize_ff;
      size_in      = size_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      mul_in       = mul_ff;
      acc_in       = acc_ff;
      top_in       = top_ff;
      mark_in      = mark_ff;
      used_in      = used_ff;
      peak_in      = peak_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = top_ff[SLOT_W-1:0];
      wr_data      = q_ff[SLOT_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               size_in   = size_eff;
               status_in = ST_OK;
               if (req_data.opcode == OP_ALLOC) begin
                  if (top_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_WB;
                  end else begin
                     state_in = S_RD;
                  end
               end else if (!req_data.ptr_valid) begin
                  status_in = ST_NULL;
                  state_in  = S_WB;
               end else if (used_ff == '0) begin
                  status_in = ST_NONE_OUT;
                  state_in  = S_WB;
               end else begin
                  q_in     = req_data.free_offset;
                  rem_in   = '0;
                  cnt_in   = CNT_W'(OFF_W);
                  state_in = S_DIV;
               end
            end
         end
         S_RD: begin
            // Below the low-water mark the entry still holds its reset value.
            mul_in   = (top_ff == mark_ff) ? rd_addr : rd_data_ff;
            acc_in   = '0;
            cnt_in   = CNT_W'(SLOT_W);
            state_in = S_MUL;
         end
         S_MUL: begin
            acc_in = unit_sum[AOFF_W-1:0];
            mul_in = mul_ff << 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_WB;
            end
         end
         S_DIV: begin
            // Carry out of the subtract means the shifted remainder covers size.
            if (unit_sum[UNIT_W]) begin
               rem_in = unit_sum[SIZE_W-1:0];
            end else begin
               rem_in = div_shift[SIZE_W-1:0];
            end
            q_in   = {q_ff[OFF_W-2:0], unit_sum[UNIT_W]};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (op_ff == OP_ALLOC && final_status == ST_OK) begin
                  top_in  = top_ff - TOP_W'(1);
                  used_in = used_ff + TOP_W'(1);
                  if (used_in > peak_ff) begin
                     peak_in = used_in;
                  end
                  if (top_in < mark_ff) begin
                     mark_in = top_in;
                  end
               end else if (op_ff == OP_FREE && final_status == ST_OK &&
                            top_ff < TOP_W'(POOL_SLOTS)) begin
                  wr_en   = 1'b1;
                  top_in  = top_ff + TOP_W'(1);
                  used_in = used_ff - TOP_W'(1);
               end
               rsp_in.status       = final_status;
               rsp_in.alloc_offset = (op_ff == OP_ALLOC && final_status == ST_OK) ?
                                     acc_ff : '0;
               rsp_in.in_use       = COUNT_W'(used_in);
               rsp_in.peak_in_use  = COUNT_W'(peak_in);
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         esize_ff     <= ESIZE_RESET;
         top_ff       <= TOP_W'(POOL_SLOTS);
         mark_ff      <= TOP_W'(POOL_SLOTS);
         used_ff      <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         esize_ff     <= esize_in;
         top_ff       <= top_in;
         mark_ff      <= mark_in;
         used_ff      <= used_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Datapath: no reset needed
   always_ff @(posedge clock) begin
      size_ff   <= size_in;
      op_ff     <= op_in;
      status_ff <= status_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      mul_ff    <= mul_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
   end

   // Stack memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // Free and used slots always add up to the pool
   a_conserve: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, top_ff} + {1'b0, used_ff}) == (TOP_W + 1)'(POOL_SLOTS))
      else $error("free plus used slots differ from pool size");

   a_mark: assert property (@(posedge clock) disable iff (reset)
      mark_ff <= top_ff)
      else $error("low-water mark above stack pointer");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= used_ff)
      else $error("peak below in-use count");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_WB)
      else $error("response raised outside write-back");

   a_wb_leave: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB && !(rsp_valid_ff && rsp_stall)) |=>
         (state_ff == S_IDLE && rsp_valid_ff))
      else $error("write-back did not complete");
`endif

endmodule
